>>> rtl/l2lb_pkg.sv
package l2lb_pkg;

    localparam int MAC_ENTRIES_DEF = 4096;
    localparam int PORT_COUNT_DEF  = 256;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_DROP    = 2'd0,
        ACT_FLOOD   = 2'd1,
        ACT_FORWARD = 2'd2,
        ACT_WRITE   = 2'd3
    } t_action;

    // Item classes decided by the front end
    typedef enum logic [1:0] {
        K_FRAME = 2'd0,
        K_SHORT = 2'd1,
        K_CMD   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [7:0]  in_port;
        logic        has_vlan;
        logic [7:0]  table_port;
        logic [11:0] table_vlan;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [7:0]  out_port;
        logic        strip_tag;
        logic        push_tag;
        logic [11:0] push_vlan;
    } t_result;

endpackage

>>> rtl/l2lb_front.sv
module l2lb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_command,
    input  logic [47:0]    i_src_mac,
    input  logic [47:0]    i_dst_mac,
    input  logic [7:0]     i_in_port,
    input  logic           i_has_vlan,
    input  logic           i_frame_short,
    input  logic [7:0]     i_table_port,
    input  logic [11:0]    i_table_vlan,
    output logic           o_item_valid,
    input  logic           i_item_ready,
    output l2lb_pkg::t_item o_item
);

    l2lb_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    l2lb_pkg::t_item w_item;
    logic            w_push, w_pop;

    // Classify the incoming transaction
    always_comb begin
        w_item.kind       = i_command ? l2lb_pkg::K_CMD :
                            (i_frame_short ? l2lb_pkg::K_SHORT : l2lb_pkg::K_FRAME);
        w_item.src_mac    = i_src_mac;
        w_item.dst_mac    = i_dst_mac;
        w_item.in_port    = i_in_port;
        w_item.has_vlan   = i_has_vlan;
        w_item.table_port = i_table_port;
        w_item.table_vlan = i_table_vlan;
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    // Two-entry queue toward the engine
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> rtl/l2lb_engine.sv
module l2lb_engine #(
    parameter int MAC_ENTRIES = l2lb_pkg::MAC_ENTRIES_DEF,
    parameter int PORT_COUNT  = l2lb_pkg::PORT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  l2lb_pkg::t_item   i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output l2lb_pkg::t_result o_res
);

    localparam int AW  = $clog2(MAC_ENTRIES);
    localparam int CW  = $clog2(MAC_ENTRIES + 1);
    localparam int VD  = (PORT_COUNT < 256) ? PORT_COUNT : 256;
    localparam int VAW = (VD > 1) ? $clog2(VD) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAC_ENTRIES);
    localparam logic [8:0]    PLIM = 9'(VD);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_LEARN = 5'b00100,
        S_VLAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  port;
    } t_entry;

    t_state            r_state;
    l2lb_pkg::t_item   r_item;
    l2lb_pkg::t_result r_res;
    logic [CW-1:0]     r_count, r_issue;
    logic              r_pend;
    logic [AW-1:0]     r_chk, r_src_idx;
    logic              r_src_found, r_dst_found;
    logic [7:0]        r_dst_port;

    t_entry            mac_mem [MAC_ENTRIES];
    t_entry            r_rd_data;
    logic              w_rd_en, w_wr_en;
    logic [AW-1:0]     w_wr_addr;

    logic [11:0]       vlan_mem [VD];
    logic [VD-1:0]     r_vv;
    logic [11:0]       r_vdata;
    logic              r_vhit;
    logic              w_vrd;
    logic              w_fwd;
    logic [7:0]        w_eport;
    logic [11:0]       w_vid;

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

    // Scan reads one stored station per cycle, learn writes one unless the table is full and the source is new
    assign w_rd_en   = (r_state == S_SCAN) && (r_issue < r_count);
    assign w_wr_en   = (r_state == S_LEARN) && (r_src_found || (r_count < FULL));
    assign w_wr_addr = r_src_found ? r_src_idx : r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rd_data <= mac_mem[r_issue[AW-1:0]];
        if (w_wr_en) mac_mem[w_wr_addr] <= '{mac: r_item.src_mac, port: r_item.in_port};
    end

    // Destination decision; learning precedes the lookup
    always_comb begin
        w_fwd   = 1'b0;
        w_eport = r_dst_port;
        if (r_item.dst_mac == l2lb_pkg::MAC_BCAST) begin
            w_fwd = 1'b0;
        end else if (r_item.dst_mac == r_item.src_mac) begin
            w_fwd   = r_src_found || (r_count < FULL);
            w_eport = r_item.in_port;
        end else begin
            w_fwd = r_dst_found;
        end
    end

    assign w_vrd = (r_state == S_LEARN) && w_fwd;
    assign w_vid = r_vhit ? r_vdata : 12'd0;

    // Port VLAN store, entries beyond the port range read as untagged
    always_ff @(posedge i_clk) begin
        if (w_vrd) begin
            r_vdata <= vlan_mem[w_eport[VAW-1:0]];
        end
        if (o_item_ready && i_item_valid && i_item.kind == l2lb_pkg::K_CMD
                && {1'b0, i_item.table_port} < PLIM) begin
            vlan_mem[i_item.table_port[VAW-1:0]] <= i_item.table_vlan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_vv    <= '0;
            r_vhit  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (w_vrd) begin
                r_vhit <= ({1'b0, w_eport} < PLIM) && r_vv[w_eport[VAW-1:0]];
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item      <= i_item;
                        r_issue     <= '0;
                        r_pend      <= 1'b0;
                        r_src_found <= 1'b0;
                        r_dst_found <= 1'b0;
                        case (i_item.kind)
                            l2lb_pkg::K_CMD: begin
                                if ({1'b0, i_item.table_port} < PLIM) begin
                                    r_vv[i_item.table_port[VAW-1:0]] <= 1'b1;
                                end
                                r_res   <= {l2lb_pkg::ACT_WRITE, i_item.table_port, 14'd0};
                                r_state <= S_DONE;
                            end
                            l2lb_pkg::K_FRAME: begin
                                r_res   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) r_issue <= r_issue + 1'b1;
                    r_pend <= w_rd_en;
                    r_chk  <= r_issue[AW-1:0];
                    if (r_pend) begin
                        if (r_rd_data.mac == r_item.src_mac) begin
                            r_src_found <= 1'b1;
                            r_src_idx   <= r_chk;
                        end
                        if (r_rd_data.mac == r_item.dst_mac) begin
                            r_dst_found <= 1'b1;
                            r_dst_port  <= r_rd_data.port;
                        end
                    end
                    if (!w_rd_en && !r_pend) r_state <= S_LEARN;
                end
                S_LEARN: begin
                    if (!r_src_found && (r_count < FULL)) r_count <= r_count + 1'b1;
                    if (w_fwd) begin
                        r_res   <= {l2lb_pkg::ACT_FORWARD, w_eport, r_item.has_vlan,
                                    1'b0, 12'd0};
                        r_state <= S_VLAN;
                    end else begin
                        r_res   <= {l2lb_pkg::ACT_FLOOD, r_item.in_port, r_item.has_vlan,
                                    1'b0, 12'd0};
                        r_state <= S_DONE;
                    end
                end
                S_VLAN: begin
                    r_res   <= {r_res.action, r_res.out_port, r_res.strip_tag,
                                (w_vid != 12'd0), w_vid};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/l2_learning_bridge.sv
// Learning Ethernet bridge, one frame header or VLAN table write per transaction.
// A two-entry queue takes transactions while the engine works. A table write or
// a short frame goes from the engine's idle state straight to its done state. For a
// frame header the engine reads the learned stations from the station memory one
// entry per cycle to match source and destination together, then learns the source
// with one write and reads the port VLAN store once for a forward. A finished
// result sits in an output register until taken. Stations are never aged out;
// once the table is full new stations are not learned.
module l2_learning_bridge #(
    parameter int MAC_ENTRIES = l2lb_pkg::MAC_ENTRIES_DEF,
    parameter int PORT_COUNT  = l2lb_pkg::PORT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [47:0] i_src_mac,
    input  logic [47:0] i_dst_mac,
    input  logic [7:0]  i_in_port,
    input  logic        i_has_vlan,
    input  logic        i_frame_short,
    input  logic [7:0]  i_table_port,
    input  logic [11:0] i_table_vlan,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_action,
    output logic [7:0]  o_out_port,
    output logic        o_strip_tag,
    output logic        o_push_tag,
    output logic [11:0] o_push_vlan
);

    l2lb_pkg::t_item   w_item;
    logic              w_item_valid, w_item_ready;
    l2lb_pkg::t_result w_res, r_out;
    logic              w_res_valid, w_res_ready;
    logic              r_ov;

    l2lb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_src_mac    (i_src_mac),
        .i_dst_mac    (i_dst_mac),
        .i_in_port    (i_in_port),
        .i_has_vlan   (i_has_vlan),
        .i_frame_short(i_frame_short),
        .i_table_port (i_table_port),
        .i_table_vlan (i_table_vlan),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    l2lb_engine #(
        .MAC_ENTRIES(MAC_ENTRIES),
        .PORT_COUNT (PORT_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(w_item_valid),
        .o_item_ready(w_item_ready),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Output register
    assign w_res_ready = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) r_out <= w_res;
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_ready) begin
            r_ov <= w_res_valid;
        end
    end

    assign o_valid     = r_ov;
    assign o_action    = r_out.action;
    assign o_out_port  = r_out.out_port;
    assign o_strip_tag = r_out.strip_tag;
    assign o_push_tag  = r_out.push_tag;
    assign o_push_vlan = r_out.push_vlan;

    // Checks
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_push_only_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_push_tag |-> o_action == l2lb_pkg::ACT_FORWARD && o_push_vlan != 12'd0)
        else $error("tag pushed on a non-forward result");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == l2lb_pkg::ACT_WRITE || o_action == l2lb_pkg::ACT_DROP)
        |-> !o_strip_tag && !o_push_tag && o_push_vlan == 12'd0)
        else $error("tag fields set on drop or table write");

    a_drop_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == l2lb_pkg::ACT_DROP |-> o_out_port == 8'd0)
        else $error("drop carries a port");

endmodule

>>> verif/l2lb_checker.sv
`timescale 1ns / 1ps

module l2lb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [47:0] i_src_mac,
    input  logic [47:0] i_dst_mac,
    input  logic [7:0]  i_in_port,
    input  logic        i_has_vlan,
    input  logic        i_frame_short,
    input  logic [7:0]  i_table_port,
    input  logic [11:0] i_table_vlan,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_out_port,
    input  logic        i_strip_tag,
    input  logic        i_push_tag,
    input  logic [11:0] i_push_vlan,
    output int          o_errors,
    output int          o_pending
);

    localparam int STATIONS = 4096;
    localparam int PORTS    = 256;

    // Model copy of the learned stations and port VLAN store
    logic [47:0]       station_mac  [STATIONS];
    logic [7:0]        station_port [STATIONS];
    int                station_count;
    logic [11:0]       port_vid     [PORTS];
    l2lb_pkg::t_result expected_q[$];

    function automatic int lookup_station(logic [47:0] mac);
        for (int i = 0; i < station_count; i++)
            if (station_mac[i] == mac) return i;
        return -1;
    endfunction

    // Resolve one transaction and update the model state
    function automatic l2lb_pkg::t_result bridge_decision();
        l2lb_pkg::t_result r;
        int                idx;
        r = '0;
        if (i_command) begin
            port_vid[i_table_port] = i_table_vlan;
            r.action   = l2lb_pkg::ACT_WRITE;
            r.out_port = i_table_port;
            return r;
        end
        if (i_frame_short) return r;
        // learn source first
        idx = lookup_station(i_src_mac);
        if (idx >= 0) begin
            station_port[idx] = i_in_port;
        end else if (station_count < STATIONS) begin
            station_mac[station_count]  = i_src_mac;
            station_port[station_count] = i_in_port;
            station_count++;
        end
        r.strip_tag = i_has_vlan;
        idx = (i_dst_mac == l2lb_pkg::MAC_BCAST) ? -1 : lookup_station(i_dst_mac);
        if (idx < 0) begin
            r.action   = l2lb_pkg::ACT_FLOOD;
            r.out_port = i_in_port;
        end else begin
            r.action   = l2lb_pkg::ACT_FORWARD;
            r.out_port = station_port[idx];
            if (port_vid[r.out_port] != 0) begin
                r.push_tag  = 1'b1;
                r.push_vlan = port_vid[r.out_port];
            end
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        l2lb_pkg::t_result exp_r;
        l2lb_pkg::t_result got;
        if (!i_rst_n) begin
            station_count = 0;
            for (int i = 0; i < PORTS; i++) port_vid[i] = '0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_valid && i_in_ready) expected_q.push_back(bridge_decision());
            if (i_out_valid && i_out_ready) begin
                got = '{l2lb_pkg::t_action'(i_action), i_out_port, i_strip_tag, i_push_tag,
                        i_push_vlan};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== got) begin
                        $display("%0t: result expected %h actual %h", $time, exp_r, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_ITEMS   = 1550;
    localparam int MAX_CYCLE = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = 1'b0;
    logic [47:0] src_mac = '0;
    logic [47:0] dst_mac = '0;
    logic [7:0]  in_port = '0;
    logic        has_vlan = 1'b0;
    logic        frame_short = 1'b0;
    logic [7:0]  table_port = '0;
    logic [11:0] table_vlan = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  action;
    logic [7:0]  out_port;
    logic        strip_tag;
    logic        push_tag;
    logic [11:0] push_vlan;
    int          errors;
    int          pending;
    int          cycle = 0;
    bit          hold_sink = 1'b0;
    logic [47:0] station_pool [32];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    l2_learning_bridge i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_command(command), .i_src_mac(src_mac), .i_dst_mac(dst_mac),
        .i_in_port(in_port), .i_has_vlan(has_vlan), .i_frame_short(frame_short),
        .i_table_port(table_port), .i_table_vlan(table_vlan),
        .o_valid(out_valid), .i_ready(out_ready), .o_action(action),
        .o_out_port(out_port), .o_strip_tag(strip_tag), .o_push_tag(push_tag),
        .o_push_vlan(push_vlan)
    );

    l2lb_checker i_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_command(command), .i_src_mac(src_mac), .i_dst_mac(dst_mac),
        .i_in_port(in_port), .i_has_vlan(has_vlan), .i_frame_short(frame_short),
        .i_table_port(table_port), .i_table_vlan(table_vlan),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_action(action),
        .i_out_port(out_port), .i_strip_tag(strip_tag), .i_push_tag(push_tag),
        .i_push_vlan(push_vlan), .o_errors(errors), .o_pending(pending)
    );

    function automatic logic [47:0] rand_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    // Offer one transaction and hold it until taken; valid stays up afterward
    task automatic send_item(bit cmd, logic [47:0] s, logic [47:0] d, logic [7:0] p,
                             bit v, bit sh, logic [7:0] tp, logic [11:0] tv);
        command <= cmd; src_mac <= s; dst_mac <= d; in_port <= p;
        has_vlan <= v; frame_short <= sh; table_port <= tp; table_vlan <= tv;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic stop_send();
        in_valid <= 1'b0;
    endtask

    task automatic send_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic random_frame();
        logic [47:0] s;
        logic [47:0] d;
        int          pick;
        pick = $urandom_range(0, 15);
        s = (pick < 12) ? station_pool[$urandom_range(0, 31)] : rand_mac();
        pick = $urandom_range(0, 15);
        d = (pick < 10) ? station_pool[$urandom_range(0, 31)] :
            (pick < 12) ? l2lb_pkg::MAC_BCAST : rand_mac();
        send_item(1'b0, s, d, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, 4095)));
    endtask

    // Cycle limit
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("l2_learning_bridge: mismatch");
            $finish;
        end
    end

    // Result side: random stall per transaction, plus one long hold-off
    initial begin
        int wait_n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (wait_n != 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int k;
        for (int i = 0; i < 32; i++) station_pool[i] = rand_mac();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, short frame, broadcast, self-forward, tags
        send_item(1'b0, '0, '0, 8'd0, 1'b0, 1'b1, 8'hFF, 12'hFFF);
        send_item(1'b0, '1, '1, 8'hFF, 1'b1, 1'b1, 8'hFF, 12'hFFF);
        send_item(1'b0, '0, l2lb_pkg::MAC_BCAST, 8'd0, 1'b1, 1'b0, 8'd0, 12'd0);
        send_item(1'b0, 48'h0000_0000_0001, '0, 8'd3, 1'b0, 1'b0, 8'd0, 12'd0);
        send_item(1'b0, 48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFE, 8'hFF, 1'b1, 1'b0,
                  8'd0, 12'd0);
        send_item(1'b1, '0, '0, 8'd0, 1'b0, 1'b0, 8'hFF, 12'hFFF);
        send_item(1'b1, '1, '1, 8'hFF, 1'b1, 1'b1, 8'd0, 12'h001);
        send_item(1'b0, 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFE, 8'd0, 1'b0, 1'b0,
                  8'd0, 12'd0);
        send_item(1'b0, '1, '0, 8'h80, 1'b1, 1'b0, 8'd0, 12'd0);
        send_item(1'b0, '0, 48'h0000_0000_0001, 8'd9, 1'b0, 1'b0, 8'd0, 12'd0);
        send_item(1'b1, '0, '0, 8'd0, 1'b0, 1'b0, 8'hFF, 12'd0);
        send_item(1'b0, '0, 48'hFFFF_FFFF_FFFE, 8'h55, 1'b0, 1'b0, 8'd0, 12'd0);
        stop_send();

        // Sender pauses until every expected result has arrived
        wait (pending == 0);
        repeat (20) @(negedge clk);

        // Back-pressure: sink holds off while the source keeps offering
        hold_sink = 1'b1;
        for (k = 0; k < 20; k++) random_frame();

        for (k = 0; k < N_ITEMS; k++) begin
            send_gap();
            if ($urandom_range(0, 9) == 0)
                send_item(1'b1, rand_mac(), rand_mac(), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)),
                          $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 4095)));
            else
                random_frame();
        end
        stop_send();

        wait (pending == 0);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("l2_learning_bridge: match");
        else
            $display("l2_learning_bridge: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/l2lb_pkg.sv
rtl/l2lb_front.sv
rtl/l2lb_engine.sv
rtl/l2_learning_bridge.sv
verif/l2lb_checker.sv
verif/tb.sv
